>>> rtl/core/ppd_pkg.sv
`timescale 1ns / 1ps
package ppd_pkg;
	localparam int MaxPoints = 64;
	localparam int IdxW = $clog2(MaxPoints);
	localparam int CntW = 7;
	localparam int CoordW = 24;
	localparam int DiffW = CoordW + 1;
	localparam int SqW = 2 * DiffW + 1;
	localparam int TBits = 16;
	localparam int OutW = 28;
	localparam int SqrtW = SqW;
	localparam logic [OutW-1:0] Sentinel = OutW'(256000000);

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic [IdxW-1:0]          idx;
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
	} item_t;
endpackage

>>> rtl/core/ppd_ram.sv
`timescale 1ns / 1ps
module ppd_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/ppd_front.sv
`timescale 1ns / 1ps
module ppd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ppd_pkg::item_t  in_item,
	output logic            q_valid,
	input  logic            q_pop,
	output ppd_pkg::item_t  q_item
);
	ppd_pkg::item_t mem_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = cnt_q == 2'd2;
	assign push = in_valid && !in_stall;
	assign q_valid = cnt_q != 2'd0;
	assign q_item = mem_q[rd_q];

	// two-entry queue between accept and execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end
endmodule

>>> rtl/core/ppd_back.sv
`timescale 1ns / 1ps
module ppd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ppd_pkg::CntW-1:0]  vcount,
	input  logic                      q_valid,
	output logic                      q_pop,
	input  ppd_pkg::item_t            q_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ppd_pkg::OutW-1:0]  distance
);
	localparam int IW = ppd_pkg::IdxW;
	localparam int CW = ppd_pkg::CoordW;
	localparam int DW = ppd_pkg::DiffW;
	localparam int SW = ppd_pkg::SqW;
	localparam int TB = ppd_pkg::TBits;
	localparam int RW = ppd_pkg::SqrtW;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RD0   = 10'b0000000010,
		S_RD1   = 10'b0000000100,
		S_PREP  = 10'b0000001000,
		S_MUL   = 10'b0000010000,
		S_DIV   = 10'b0000100000,
		S_OFF   = 10'b0001000000,
		S_SQ    = 10'b0010000000,
		S_SQRT  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t st_q;
	logic [IW-1:0] raddr;
	logic [CW-1:0] rx, ry;
	logic ld;
	logic [IW:0] seg_q, n_q;
	logic signed [CW-1:0] px_q, py_q, x1_q, y1_q;
	logic signed [DW-1:0] sx_q, sy_q, tx_q, ty_q;
	logic signed [SW-1:0] dot_q;
	logic [SW-1:0] len_q, rem_q, best_q;
	logic have_q;
	logic [TB:0] t_q;
	logic [4:0] it_q;
	logic signed [DW+TB+1:0] ox_q, oy_q;
	logic signed [DW+1:0] dx_q, dy_q;
	logic [SW-1:0] v_q;
	logic [RW-1:0] res_q;
	logic [SW-1:0] bit_q;
	logic [ppd_pkg::OutW-1:0] dist_q;
	logic vld_q;

	assign ld = q_valid && (st_q == S_IDLE) && (q_item.op == ppd_pkg::OP_LOAD);
	assign q_pop = q_valid && (st_q == S_IDLE) &&
		(q_item.op == ppd_pkg::OP_LOAD || !vld_q);
	assign raddr = (st_q == S_RD0) ? seg_q[IW-1:0] : seg_q[IW-1:0] + IW'(1);

	ppd_ram #(.Width(CW), .Depth(ppd_pkg::MaxPoints)) u_ramx (
		.clk(clk), .we(ld), .waddr(q_item.idx), .wdata(q_item.x),
		.raddr(raddr), .rdata(rx));
	ppd_ram #(.Width(CW), .Depth(ppd_pkg::MaxPoints)) u_ramy (
		.clk(clk), .we(ld), .waddr(q_item.idx), .wdata(q_item.y),
		.raddr(raddr), .rdata(ry));

	assign out_valid = vld_q;
	assign distance = dist_q;

	logic [SW:0] trial;
	logic [SW-1:0] rsh;
	logic signed [DW+TB+1:0] fx, fy;
	logic [SW-1:0] sqb;
	logic [SW-1:0] sq_sum;
	always_comb begin
		rsh = {rem_q[SW-2:0], 1'b0};
		trial = {1'b0, rsh} - {1'b0, len_q};
		fx = ox_q >>> TB;
		fy = oy_q >>> TB;
		sqb = SW'(res_q) + bit_q;
		sq_sum = SW'(dx_q * dx_q) + SW'(dy_q * dy_q);
	end

	// segment walk: read, project, divide, offset, square, keep least, square root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			vld_q <= 1'b0;
		end else begin
			if (vld_q && !out_stall) vld_q <= 1'b0;
			case (st_q)
				S_IDLE: if (q_valid && q_item.op == ppd_pkg::OP_QUERY && !vld_q) begin
					px_q <= q_item.x;
					py_q <= q_item.y;
					seg_q <= '0;
					have_q <= 1'b0;
					n_q <= (vcount > 7'(ppd_pkg::MaxPoints)) ?
						(IW+1)'(ppd_pkg::MaxPoints) : vcount[IW:0];
					if (vcount < 7'd2) begin
						dist_q <= ppd_pkg::Sentinel;
						st_q <= S_OUT;
					end else st_q <= S_RD0;
				end
				S_RD0: st_q <= S_RD1;
				S_RD1: begin
					x1_q <= rx;
					y1_q <= ry;
					st_q <= S_PREP;
				end
				S_PREP: begin
					sx_q <= DW'(signed'(rx)) - DW'(x1_q);
					sy_q <= DW'(signed'(ry)) - DW'(y1_q);
					tx_q <= DW'(px_q) - DW'(x1_q);
					ty_q <= DW'(py_q) - DW'(y1_q);
					st_q <= S_MUL;
				end
				S_MUL: begin
					dot_q <= SW'(tx_q * sx_q) + SW'(ty_q * sy_q);
					len_q <= SW'(sx_q * sx_q) + SW'(sy_q * sy_q);
					it_q <= '0;
					st_q <= S_DIV;
				end
				S_DIV: begin
					if (it_q == 5'd0) begin
						rem_q <= dot_q;
						it_q <= 5'd1;
						if (len_q == '0 || dot_q <= 0) begin
							t_q <= '0;
							st_q <= S_OFF;
						end else if (dot_q >= signed'(len_q)) begin
							t_q <= (TB+1)'(1) << TB;
							st_q <= S_OFF;
						end else t_q <= '0;
					end else begin
						if (!trial[SW]) begin
							rem_q <= trial[SW-1:0];
							t_q <= {t_q[TB-1:0], 1'b1};
						end else begin
							rem_q <= rsh;
							t_q <= {t_q[TB-1:0], 1'b0};
						end
						it_q <= it_q + 5'd1;
						if (it_q == 5'(TB)) st_q <= S_OFF;
					end
				end
				S_OFF: begin
					ox_q <= (DW+TB+2)'(sx_q * signed'({1'b0, t_q}));
					oy_q <= (DW+TB+2)'(sy_q * signed'({1'b0, t_q}));
					st_q <= S_SQ;
				end
				S_SQ: begin
					dx_q <= (DW+2)'(tx_q) - (DW+2)'(fx);
					dy_q <= (DW+2)'(ty_q) - (DW+2)'(fy);
					it_q <= '0;
					st_q <= S_SQRT;
					seg_q <= seg_q + 1'b1;
				end
				S_SQRT: begin
					if (it_q == 5'd0) begin
						if (!have_q || sq_sum < best_q) best_q <= sq_sum;
						have_q <= 1'b1;
						if (seg_q + 1'b1 < n_q) st_q <= S_RD0;
						else begin
							v_q <= (!have_q || sq_sum < best_q) ? sq_sum : best_q;
							res_q <= '0;
							bit_q <= SW'(1) << (SW - 1 - (SW % 2 == 0 ? 1 : 0) + 1 - 1);
							it_q <= 5'd1;
						end
					end else if (bit_q == '0) begin
						dist_q <= (res_q > RW'(ppd_pkg::Sentinel)) ?
							ppd_pkg::Sentinel : res_q[ppd_pkg::OutW-1:0];
						st_q <= S_OUT;
					end else begin
						if (v_q >= sqb) begin
							v_q <= v_q - sqb;
							res_q <= RW'((SW'(res_q) >> 1) + bit_q);
						end else res_q <= res_q >> 1;
						bit_q <= bit_q >> 2;
					end
				end
				S_OUT: begin
					vld_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/core/point_to_polyline_distance_top.sv
`timescale 1ns / 1ps
// Point to polyline distance. Load items (operation 0) write one vertex into its
// slot and give no result; query items (operation 1) give one distance as an
// unsigned integer in coordinate units. A query walks min(vertex_count,64)-1
// segments one at a time, each through two RAM reads, a dot/length multiply,
// a 16-step restoring divide, offset and square, the divide being skipped when
// the projection clamps or the segment has zero length, then takes a 26-step
// square root of the least squared distance. Fewer than two vertices give the
// sentinel 256000000, and results above it are clamped to it.
// A two-entry queue decouples acceptance from the segment engine. Write
// vertex_count only while no item is in flight, and load every vertex a query
// will read.
module point_to_polyline_distance_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [5:0]  vertex_index,
	input  logic signed [23:0] coord_x,
	input  logic signed [23:0] coord_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [27:0] distance
);
	logic [6:0] vcount_q;
	ppd_pkg::item_t in_item, q_item;
	logic q_valid, q_pop;

	// hold vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= '0;
		else if (cfg_we) vcount_q <= cfg_wdata;
	end

	assign in_item = '{op: ppd_pkg::op_t'(operation), idx: vertex_index,
		x: coord_x, y: coord_y};

	ppd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item));

	ppd_back u_back (
		.clk(clk), .arst_n(arst_n), .vcount(vcount_q), .q_valid(q_valid),
		.q_pop(q_pop), .q_item(q_item), .out_valid(out_valid),
		.out_stall(out_stall), .distance(distance));
endmodule

>>> rtl/core/ppd_checker.sv
`timescale 1ns / 1ps
module ppd_props (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [27:0] distance
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance))
		else $error("stalled result changed");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance <= 28'd256000000)
		else $error("distance above sentinel");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("results back to back");
endmodule

bind point_to_polyline_distance_top ppd_props u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_stall(out_stall), .distance(distance));
